### rtl/iaq_pkg.sv
// ----------------------------------------------------------------------------
// iaq_pkg: shared types and constants for the int8 absmax quantizer
// Word formats for both channels, block sizing and fixed-point constants.
// ----------------------------------------------------------------------------
package iaq_pkg;

   // block sizing
   localparam int BLOCK_DEPTH = 64;
   localparam int IDX_W       = (BLOCK_DEPTH > 1) ? $clog2(BLOCK_DEPTH) : 1;
   localparam int CNT_W       = $clog2(BLOCK_DEPTH + 1);

   // field widths
   localparam int SAMPLE_W = 24;
   localparam int CODE_W   = 8;

   // divider operand widths: numerator 254*mag + m < 2^31, divisor 2*m <= 2^24
   localparam int NUM_W  = 31;
   localparam int DEN_W  = SAMPLE_W + 1;
   localparam int QUO_W  = 8;
   localparam int STEP_W = $clog2(QUO_W);

   // fixed-point constants
   localparam logic [SAMPLE_W-1:0] ONE_Q16    = SAMPLE_W'(65536);
   localparam logic [CODE_W-1:0]   CODE_LIMIT = CODE_W'(127);
   localparam logic [CODE_W-1:0]   TWICE_LIMIT = CODE_W'(254);

   // input word
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       last;
   } req_word_type;

   // result word
   typedef struct packed {
      logic signed [CODE_W-1:0] code;
      logic [SAMPLE_W-1:0]      max_magnitude;
      logic                     last_res;
   } rsp_word_type;

   // divider status toward the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   // magnitude of a two's complement sample; most negative gives 2^23
   function automatic logic [SAMPLE_W-1:0] abs_sample(input logic [SAMPLE_W-1:0] s);
      abs_sample = s[SAMPLE_W-1] ? (~s + SAMPLE_W'(1)) : s;
   endfunction

endpackage

### rtl/iaq_div.sv
// ----------------------------------------------------------------------------
// iaq_div: iterative restoring divider
// Produces an 8-bit quotient, one bit per cycle, for numerators known to be
// below 256 times the divisor.
// ----------------------------------------------------------------------------
module iaq_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [iaq_pkg::NUM_W-1:0]        numerator,
   input  logic [iaq_pkg::DEN_W-1:0]        divisor,
   output iaq_pkg::div_status_type          status,
   output logic [iaq_pkg::QUO_W-1:0]        quotient
);

   localparam int SH_W = iaq_pkg::DEN_W + iaq_pkg::QUO_W - 1;

   logic [iaq_pkg::NUM_W-1:0]  rem_ff, rem_in;
   logic [SH_W-1:0]            dsh_ff, dsh_in;
   logic [iaq_pkg::QUO_W-1:0]  quo_ff, quo_in;
   logic [iaq_pkg::STEP_W-1:0] step_ff, step_in;
   logic                       busy_ff, busy_in;
   logic                       fits;
   logic                       last_step;

   // trial subtract against the shifted divisor
   assign fits      = SH_W'(rem_ff) >= dsh_ff;
   assign last_step = step_ff == iaq_pkg::STEP_W'(iaq_pkg::QUO_W - 1);

   always_comb begin
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      quo_in  = quo_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      if (start) begin
         rem_in  = numerator;
         dsh_in  = {divisor, (iaq_pkg::QUO_W - 1)'(0)};
         quo_in  = '0;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = rem_ff - iaq_pkg::NUM_W'(dsh_ff);
         end
         dsh_in  = dsh_ff >> 1;
         quo_in  = {quo_ff[iaq_pkg::QUO_W-2:0], fits};
         step_in = step_ff + iaq_pkg::STEP_W'(1);
         busy_in = !last_step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      rem_ff  <= rem_in;
      dsh_ff  <= dsh_in;
      quo_ff  <= quo_in;
      step_ff <= step_in;
   end

   // final bit joins the quotient in the cycle it is found
   assign status.busy = busy_ff;
   assign status.done = busy_ff && last_step;
   assign quotient    = {quo_ff[iaq_pkg::QUO_W-2:0], fits};

endmodule

### rtl/int8_absmax_quantizer_unit.sv
// ----------------------------------------------------------------------------
// int8_absmax_quantizer_unit: symmetric int8 absmax quantizer
// Buffers a block of Q7.16 samples and emits one int8 code per sample.
// ----------------------------------------------------------------------------
// Samples load at one word per cycle into a 64-entry store while the largest
// magnitude is tracked. The word flagged last starts emission: the input is
// stalled and the store is walked in arrival order, each code being
// round(sample*127/M) (half away from zero), where M is the block maximum or
// 1.0 for an all-zero block. Each code passes through one store read, one
// multiply, eight steps of the shared restoring divider and an output state
// that holds while the output is stalled. Samples beyond the store depth are
// dropped.
// ----------------------------------------------------------------------------
module int8_absmax_quantizer_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  iaq_pkg::req_word_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output iaq_pkg::rsp_word_type rsp_data
);

   localparam logic [2:0] S_LOAD = 3'd0;
   localparam logic [2:0] S_READ = 3'd1;
   localparam logic [2:0] S_MUL  = 3'd2;
   localparam logic [2:0] S_DIV  = 3'd3;
   localparam logic [2:0] S_OUT  = 3'd4;

   logic [2:0]                      state_ff, state_in;
   logic [iaq_pkg::CNT_W-1:0]       fill_ff, fill_in;
   logic [iaq_pkg::SAMPLE_W-1:0]    max_ff, max_in;
   logic [iaq_pkg::SAMPLE_W-1:0]    m_ff, m_in;
   logic [iaq_pkg::CNT_W-1:0]       count_ff, count_in;
   logic [iaq_pkg::IDX_W-1:0]       idx_ff, idx_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   iaq_pkg::rsp_word_type           rsp_data_ff, rsp_data_in;

   logic [iaq_pkg::SAMPLE_W-1:0]    store_mem [iaq_pkg::BLOCK_DEPTH];
   logic [iaq_pkg::SAMPLE_W-1:0]    rd_data_ff;

   logic                            req_take;
   logic                            rsp_take;
   logic                            store_en;
   logic [iaq_pkg::SAMPLE_W-1:0]    in_mag;
   logic [iaq_pkg::CNT_W-1:0]       fill_next;
   logic [iaq_pkg::SAMPLE_W-1:0]    max_next;
   logic [iaq_pkg::SAMPLE_W-1:0]    rd_mag;
   logic [iaq_pkg::NUM_W-1:0]       num;
   logic                            div_start;
   iaq_pkg::div_status_type         div_status;
   logic [iaq_pkg::QUO_W-1:0]       quotient;
   logic [iaq_pkg::CODE_W-1:0]      q_clamped;
   logic                            is_final;

   assign req_take = req_valid && !req_stall;
   assign rsp_take = rsp_valid_ff && !rsp_stall;

   // load side: store while room remains, track the largest magnitude
   assign in_mag    = iaq_pkg::abs_sample(req_data.sample);
   assign store_en  = req_take && (fill_ff < iaq_pkg::CNT_W'(iaq_pkg::BLOCK_DEPTH));
   assign fill_next = fill_ff + iaq_pkg::CNT_W'(store_en);
   assign max_next  = (store_en && in_mag > max_ff) ? in_mag : max_ff;

   // numerator 254*|s| + M; divisor 2*M
   assign rd_mag    = iaq_pkg::abs_sample(rd_data_ff);
   assign num       = iaq_pkg::NUM_W'(rd_mag) * iaq_pkg::NUM_W'(iaq_pkg::TWICE_LIMIT)
                      + iaq_pkg::NUM_W'(m_ff);
   assign div_start = state_ff == S_MUL;

   iaq_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .numerator (num),
      .divisor   ({m_ff, 1'b0}),
      .status    (div_status),
      .quotient  (quotient)
   );

   assign q_clamped = (quotient > iaq_pkg::CODE_LIMIT) ? iaq_pkg::CODE_LIMIT : quotient;
   assign is_final  = (iaq_pkg::CNT_W'(idx_ff) + iaq_pkg::CNT_W'(1)) == count_ff;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      max_in       = max_ff;
      m_in         = m_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         S_LOAD: begin
            if (req_take) begin
               fill_in = fill_next;
               max_in  = max_next;
               if (req_data.last) begin
                  m_in     = (max_next == '0) ? iaq_pkg::ONE_Q16 : max_next;
                  count_in = fill_next;
                  idx_in   = '0;
                  if (fill_next == '0) begin
                     fill_in = '0;
                     max_in  = '0;
                  end else begin
                     state_in = S_READ;
                  end
               end
            end
         end
         S_READ: begin
            state_in = S_MUL;
         end
         S_MUL: begin
            state_in = S_DIV;
         end
         S_DIV: begin
            if (div_status.done) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.code      = rd_data_ff[iaq_pkg::SAMPLE_W-1] ?
                                       (~q_clamped + iaq_pkg::CODE_W'(1)) : q_clamped;
               rsp_data_in.max_magnitude = m_ff;
               rsp_data_in.last_res  = is_final;
               state_in              = S_OUT;
            end
         end
         S_OUT: begin
            if (rsp_take) begin
               rsp_valid_in = 1'b0;
               if (is_final) begin
                  fill_in  = '0;
                  max_in   = '0;
                  state_in = S_LOAD;
               end else begin
                  idx_in   = idx_ff + iaq_pkg::IDX_W'(1);
                  state_in = S_READ;
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         fill_ff      <= '0;
         max_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         max_ff       <= max_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      m_ff        <= m_in;
      count_ff    <= count_in;
      idx_ff      <= idx_in;
      rsp_data_ff <= rsp_data_in;
   end

   // sample store: write on load, registered read at the emit index
   always_ff @(posedge clock) begin
      if (store_en) begin
         store_mem[fill_ff[iaq_pkg::IDX_W-1:0]] <= req_data.sample;
      end
      rd_data_ff <= store_mem[idx_ff];
   end

   assign req_stall = state_ff != S_LOAD;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### rtl/iaq_check.sv
// ----------------------------------------------------------------------------
// iaq_check: port-level checks for the int8 absmax quantizer
// Watches the top level's channels and flags out-of-range or unstable words.
// ----------------------------------------------------------------------------
module iaq_check (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input iaq_pkg::req_word_type req_data,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input iaq_pkg::rsp_word_type rsp_data
);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result word changed while stalled");

   // codes are symmetric, never the most negative int8
   a_code_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.code != 8'sh80)
      else $error("code of -128 emitted");

   // the block maximum used for scaling is never zero
   a_max_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.max_magnitude != '0)
      else $error("zero max magnitude emitted");

   // input is held off while a block is being emitted
   a_no_load_in_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input open during emission");

endmodule

bind int8_absmax_quantizer_unit iaq_check u_iaq_check (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
